[design/mesu_pkg.sv]
// ----------------------------------------------------------------------------
// mesu_pkg: shared types and constants
// Payload structs, the free-space record, register indexes and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mesu_pkg;

    localparam int CW = 16;
    localparam int CFG_ADDR_BITS = 4;

    typedef logic [CW-1:0] coord_t;
    typedef logic [CW:0]   coord_end_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        coord_t w;
        coord_t l;
        coord_t d;
    } space_t;

    typedef struct packed {
        logic   kind;
        coord_t box_x;
        coord_t box_y;
        coord_t box_z;
        coord_t box_w;
        coord_t box_l;
        coord_t box_d;
    } in_t;

    typedef struct packed {
        logic [6:0] space_count;
        coord_t     anchor_x;
        coord_t     anchor_y;
        coord_t     anchor_z;
        coord_t     anchor_w;
        coord_t     anchor_l;
        coord_t     anchor_d;
        logic       overflow;
    } out_t;

    localparam logic KIND_RESTART = 1'b0;
    localparam logic KIND_PLACE   = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    // Remainder pieces: left, right, back, front, bottom, top.
    localparam logic [2:0] PIECE_LEFT   = 3'd0;
    localparam logic [2:0] PIECE_RIGHT  = 3'd1;
    localparam logic [2:0] PIECE_BACK   = 3'd2;
    localparam logic [2:0] PIECE_FRONT  = 3'd3;
    localparam logic [2:0] PIECE_BOTTOM = 3'd4;
    localparam logic [2:0] PIECE_TOP    = 3'd5;

    typedef struct packed {
        logic accept;
        logic sp_issue;
        logic sp_gen;
        logic pr_issue;
        logic pr_load;
        logic pr_scan;
        logic an_init;
        logic an_scan;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic sp_done;
        logic sp_last;
        logic pr_empty;
        logic pr_drop;
        logic pr_end;
        logic an_end;
        logic m_free;
    } stat_t;

    // True if space a encloses space b on every axis.
    function automatic logic space_encloses(space_t a, space_t b);
        logic ok_x;
        logic ok_y;
        logic ok_z;
        ok_x = (b.x >= a.x) &&
               (({1'b0, b.x} + {1'b0, b.w}) <= ({1'b0, a.x} + {1'b0, a.w}));
        ok_y = (b.y >= a.y) &&
               (({1'b0, b.y} + {1'b0, b.l}) <= ({1'b0, a.y} + {1'b0, a.l}));
        ok_z = (b.z >= a.z) &&
               (({1'b0, b.z} + {1'b0, b.d}) <= ({1'b0, a.z} + {1'b0, a.d}));
        return ok_x && ok_y && ok_z;
    endfunction

    // Anchor order: least z, then y, then x.
    function automatic logic space_before(space_t a, space_t b);
        logic lt;
        if (a.z != b.z) begin
            lt = a.z < b.z;
        end else if (a.y != b.y) begin
            lt = a.y < b.y;
        end else begin
            lt = a.x < b.x;
        end
        return lt;
    endfunction

endpackage

[design/maximal_empty_space_update_unit.sv]
// ----------------------------------------------------------------------------
// maximal_empty_space_update_unit: free-space table for 3D box packing
// Keeps the maximal empty spaces of a container and reports the anchor space.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes a request: kind 0 restarts the table with the whole
//   container, kind 1 places a box and rebuilds the free-space table.
//   m_ channel returns one result per request: space count, anchor space
//   (least z, then y, then x) and an overflow flag.
//   The APB port holds the container width, length and depth at 0x0, 0x4,
//   0x8; write them only while no request is in flight.
// Flow:
//   A restart loads the whole container and runs the anchor search. A place
//   request first splits each table entry (one table read and up to six
//   pieces per entry), then prunes the candidates through the single
//   candidate memory read port feeding one containment comparator, then
//   runs the anchor search over the new table and loads the result.
//   One request is worked at a time; s_ready is high only while idle.
// Reset and stall:
//   Reset empties the table and sets the container to 1024 on each axis.
//   A held result stays in the output register; a finished request waits
//   until that register is free before loading its own result.
// ----------------------------------------------------------------------------
module maximal_empty_space_update_unit
    import mesu_pkg::*;
#(
    parameter int MAX_SPACES = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_t                      s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_t                     m_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    coord_t cont_w_reg;
    coord_t cont_l_reg;
    coord_t cont_d_reg;
    cmd_t   cmd;
    stat_t  stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cont_w_reg <= CW'(1024);
            cont_l_reg <= CW'(1024);
            cont_d_reg <= CW'(1024);
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_WIDTH:  cont_w_reg <= pwdata[CW-1:0];
                REG_LENGTH: cont_l_reg <= pwdata[CW-1:0];
                REG_DEPTH:  cont_d_reg <= pwdata[CW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(cont_w_reg);
            REG_LENGTH: prdata = 32'(cont_l_reg);
            REG_DEPTH:  prdata = 32'(cont_d_reg);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    mesu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    mesu_dp #(.MAX_SPACES(MAX_SPACES)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .cont_w  (cont_w_reg),
        .cont_l  (cont_l_reg),
        .cont_d  (cont_d_reg),
        .m_data  (m_data),
        .m_valid (m_valid),
        .m_ready (m_ready)
    );

endmodule

[design/mesu_ram.sv]
// ----------------------------------------------------------------------------
// mesu_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mesu_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/mesu_ctrl.sv]
// ----------------------------------------------------------------------------
// mesu_ctrl: sequencing state machine
// Steps through split, containment pruning, anchor search and result hand-off.
// ----------------------------------------------------------------------------
module mesu_ctrl
    import mesu_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    input  logic  s_kind,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SP_RD,
        ST_SP_GEN,
        ST_PR_I,
        ST_PR_IW,
        ST_PR_SCAN,
        ST_AN_INIT,
        ST_AN_SCAN,
        ST_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_kind == KIND_PLACE) ? ST_SP_RD : ST_AN_INIT;
                end
            end
            ST_SP_RD: begin
                cmd.sp_issue = 1'b1;
                state_next   = stat.sp_done ? ST_PR_I : ST_SP_GEN;
            end
            ST_SP_GEN: begin
                cmd.sp_gen = 1'b1;
                if (stat.sp_last) begin
                    state_next = ST_SP_RD;
                end
            end
            ST_PR_I: begin
                cmd.pr_issue = 1'b1;
                state_next   = stat.pr_empty ? ST_AN_INIT : ST_PR_IW;
            end
            ST_PR_IW: begin
                cmd.pr_load = 1'b1;
                state_next  = ST_PR_SCAN;
            end
            ST_PR_SCAN: begin
                cmd.pr_scan = 1'b1;
                if (stat.pr_drop || stat.pr_end) begin
                    state_next = ST_PR_I;
                end
            end
            ST_AN_INIT: begin
                cmd.an_init = 1'b1;
                state_next  = ST_AN_SCAN;
            end
            ST_AN_SCAN: begin
                cmd.an_scan = 1'b1;
                if (stat.an_end) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (stat.m_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

[design/mesu_dp.sv]
// ----------------------------------------------------------------------------
// mesu_dp: free-space datapath
// Table and candidate memories, split generator, containment comparator,
// anchor search and the result register.
// ----------------------------------------------------------------------------
module mesu_dp
    import mesu_pkg::*;
#(
    parameter int MAX_SPACES = 64
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  cmd_t   cmd,
    output stat_t  stat,
    input  in_t    s_data,
    input  coord_t cont_w,
    input  coord_t cont_l,
    input  coord_t cont_d,
    output out_t   m_data,
    output logic   m_valid,
    input  logic   m_ready
);

    localparam int STAGE_DEPTH = 6 * MAX_SPACES;
    localparam int TAW = $clog2(MAX_SPACES);
    localparam int TCW = $clog2(MAX_SPACES + 1);
    localparam int SAW = $clog2(STAGE_DEPTH);
    localparam int SCW = $clog2(STAGE_DEPTH + 1);

    // Control state.
    logic [TCW-1:0] tot_reg;
    logic [TCW-1:0] sp_idx_reg;
    logic [2:0]     k_reg;
    logic [SCW-1:0] stg_tot_reg;
    logic [SCW-1:0] pi_reg;
    logic [SCW-1:0] pj_reg;
    logic [SCW-1:0] jq_reg;
    logic           rv_reg;
    logic [TCW-1:0] kept_reg;
    logic           over_reg;
    logic [TCW-1:0] ai_reg;
    logic [TAW-1:0] aq_reg;
    logic           arv_reg;
    logic           m_valid_reg;

    // Payload.
    coord_t     lo_x_reg, lo_y_reg, lo_z_reg;
    coord_end_t hi_x_reg, hi_y_reg, hi_z_reg;
    space_t     cand_reg;
    space_t     best_reg;
    out_t       out_reg;

    space_t         tbl_rdata;
    space_t         stg_rdata;
    logic           tbl_we;
    logic [TAW-1:0] tbl_waddr;
    space_t         tbl_wdata;
    logic           tbl_re;
    logic [TAW-1:0] tbl_raddr;
    logic           stg_we;
    logic           stg_re;
    logic [SAW-1:0] stg_raddr;

    logic       restart;
    coord_end_t t_x, t_y, t_z;
    logic       ovl;
    logic       piece_ok;
    space_t     piece;
    logic       add_ok;
    logic       drop_hit;
    logic       keep_room;
    space_t     cont_space;

    assign restart = cmd.accept && (s_data.kind == KIND_RESTART);

    // Split of the current table entry into one piece per cycle.
    always_comb begin
        t_x = {1'b0, tbl_rdata.x} + {1'b0, tbl_rdata.w};
        t_y = {1'b0, tbl_rdata.y} + {1'b0, tbl_rdata.l};
        t_z = {1'b0, tbl_rdata.z} + {1'b0, tbl_rdata.d};
        ovl = (hi_x_reg > {1'b0, tbl_rdata.x}) && ({1'b0, lo_x_reg} < t_x) &&
              (hi_y_reg > {1'b0, tbl_rdata.y}) && ({1'b0, lo_y_reg} < t_y) &&
              (hi_z_reg > {1'b0, tbl_rdata.z}) && ({1'b0, lo_z_reg} < t_z);
        piece    = tbl_rdata;
        piece_ok = 1'b0;
        if (!ovl) begin
            piece_ok = 1'b1;
        end else begin
            case (k_reg)
                PIECE_LEFT: begin
                    piece_ok = lo_x_reg > tbl_rdata.x;
                    piece.w  = lo_x_reg - tbl_rdata.x;
                end
                PIECE_RIGHT: begin
                    piece_ok = hi_x_reg < t_x;
                    piece.x  = hi_x_reg[CW-1:0];
                    piece.w  = CW'(t_x - hi_x_reg);
                end
                PIECE_BACK: begin
                    piece_ok = lo_y_reg > tbl_rdata.y;
                    piece.l  = lo_y_reg - tbl_rdata.y;
                end
                PIECE_FRONT: begin
                    piece_ok = hi_y_reg < t_y;
                    piece.y  = hi_y_reg[CW-1:0];
                    piece.l  = CW'(t_y - hi_y_reg);
                end
                PIECE_BOTTOM: begin
                    piece_ok = lo_z_reg > tbl_rdata.z;
                    piece.d  = lo_z_reg - tbl_rdata.z;
                end
                PIECE_TOP: begin
                    piece_ok = hi_z_reg < t_z;
                    piece.z  = hi_z_reg[CW-1:0];
                    piece.d  = CW'(t_z - hi_z_reg);
                end
                default: begin
                    piece_ok = 1'b0;
                end
            endcase
        end
        add_ok = piece_ok && (piece.w != '0) && (piece.l != '0) && (piece.d != '0) &&
                 (stg_tot_reg < SCW'(STAGE_DEPTH));
    end

    // A candidate is dropped when an earlier identical one or any strictly
    // larger one encloses it.
    assign drop_hit = rv_reg && (jq_reg != pi_reg) &&
                      space_encloses(stg_rdata, cand_reg) &&
                      ((stg_rdata != cand_reg) || (jq_reg < pi_reg));
    assign keep_room = kept_reg < TCW'(MAX_SPACES);

    assign cont_space = '{x: '0, y: '0, z: '0, w: cont_w, l: cont_l, d: cont_d};

    assign stat.sp_done  = sp_idx_reg == tot_reg;
    assign stat.sp_last  = !ovl || (k_reg == PIECE_TOP);
    assign stat.pr_empty = pi_reg == stg_tot_reg;
    assign stat.pr_drop  = drop_hit;
    assign stat.pr_end   = !drop_hit && !rv_reg && (pj_reg == stg_tot_reg);
    assign stat.an_end   = !arv_reg && (ai_reg == tot_reg);
    assign stat.m_free   = !m_valid_reg || m_ready;

    assign tbl_we    = restart || (cmd.pr_scan && stat.pr_end && keep_room);
    assign tbl_waddr = restart ? '0 : kept_reg[TAW-1:0];
    assign tbl_wdata = restart ? cont_space : cand_reg;
    assign tbl_re    = (cmd.sp_issue && !stat.sp_done) ||
                       (cmd.an_scan && (ai_reg < tot_reg));
    assign tbl_raddr = cmd.sp_issue ? sp_idx_reg[TAW-1:0] : ai_reg[TAW-1:0];

    assign stg_we    = cmd.sp_gen && add_ok;
    assign stg_re    = (cmd.pr_issue && !stat.pr_empty) ||
                       (cmd.pr_scan && (pj_reg < stg_tot_reg));
    assign stg_raddr = cmd.pr_issue ? pi_reg[SAW-1:0] : pj_reg[SAW-1:0];

    mesu_ram #(.WIDTH($bits(space_t)), .DEPTH(MAX_SPACES)) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    mesu_ram #(.WIDTH($bits(space_t)), .DEPTH(STAGE_DEPTH)) u_stg (
        .aclk  (aclk),
        .we    (stg_we),
        .waddr (stg_tot_reg[SAW-1:0]),
        .wdata (piece),
        .re    (stg_re),
        .raddr (stg_raddr),
        .rdata (stg_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_reg     <= '0;
            sp_idx_reg  <= '0;
            k_reg       <= '0;
            stg_tot_reg <= '0;
            pi_reg      <= '0;
            pj_reg      <= '0;
            jq_reg      <= '0;
            rv_reg      <= 1'b0;
            kept_reg    <= '0;
            over_reg    <= 1'b0;
            ai_reg      <= '0;
            aq_reg      <= '0;
            arv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                over_reg    <= 1'b0;
                sp_idx_reg  <= '0;
                stg_tot_reg <= '0;
                pi_reg      <= '0;
                kept_reg    <= '0;
                if (restart) begin
                    tot_reg <= TCW'(1);
                end
            end
            if (cmd.sp_issue) begin
                k_reg <= '0;
            end
            if (cmd.sp_gen) begin
                k_reg <= k_reg + 3'd1;
                if (add_ok) begin
                    stg_tot_reg <= stg_tot_reg + SCW'(1);
                end
                if (stat.sp_last) begin
                    sp_idx_reg <= sp_idx_reg + TCW'(1);
                end
            end
            if (cmd.pr_issue && stat.pr_empty) begin
                tot_reg <= kept_reg;
            end
            if (cmd.pr_load) begin
                pj_reg <= '0;
                rv_reg <= 1'b0;
            end
            if (cmd.pr_scan) begin
                if (pj_reg < stg_tot_reg) begin
                    pj_reg <= pj_reg + SCW'(1);
                    jq_reg <= pj_reg;
                    rv_reg <= 1'b1;
                end else begin
                    rv_reg <= 1'b0;
                end
                if (drop_hit) begin
                    pi_reg <= pi_reg + SCW'(1);
                end else if (stat.pr_end) begin
                    pi_reg <= pi_reg + SCW'(1);
                    if (keep_room) begin
                        kept_reg <= kept_reg + TCW'(1);
                    end else begin
                        over_reg <= 1'b1;
                    end
                end
            end
            if (cmd.an_init) begin
                ai_reg  <= '0;
                arv_reg <= 1'b0;
            end
            if (cmd.an_scan) begin
                if (ai_reg < tot_reg) begin
                    ai_reg  <= ai_reg + TCW'(1);
                    aq_reg  <= ai_reg[TAW-1:0];
                    arv_reg <= 1'b1;
                end else begin
                    arv_reg <= 1'b0;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            lo_x_reg <= s_data.box_x;
            lo_y_reg <= s_data.box_y;
            lo_z_reg <= s_data.box_z;
            hi_x_reg <= {1'b0, s_data.box_x} + {1'b0, s_data.box_w};
            hi_y_reg <= {1'b0, s_data.box_y} + {1'b0, s_data.box_l};
            hi_z_reg <= {1'b0, s_data.box_z} + {1'b0, s_data.box_d};
        end
        if (cmd.pr_load) begin
            cand_reg <= stg_rdata;
        end
        if (cmd.an_scan && arv_reg) begin
            if ((aq_reg == '0) || space_before(tbl_rdata, best_reg)) begin
                best_reg <= tbl_rdata;
            end
        end
        if (cmd.out_load) begin
            out_reg.space_count <= 7'(tot_reg);
            out_reg.anchor_x    <= (tot_reg != '0) ? best_reg.x : '0;
            out_reg.anchor_y    <= (tot_reg != '0) ? best_reg.y : '0;
            out_reg.anchor_z    <= (tot_reg != '0) ? best_reg.z : '0;
            out_reg.anchor_w    <= (tot_reg != '0) ? best_reg.w : '0;
            out_reg.anchor_l    <= (tot_reg != '0) ? best_reg.l : '0;
            out_reg.anchor_d    <= (tot_reg != '0) ? best_reg.d : '0;
            out_reg.overflow    <= over_reg;
        end
    end

    assign m_data  = out_reg;
    assign m_valid = m_valid_reg;

`ifndef SYNTHESIS
    a_tot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tot_reg <= TCW'(MAX_SPACES))
        else $error("space count exceeds table capacity");
    a_stage_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_tot_reg <= SCW'(STAGE_DEPTH))
        else $error("candidate count exceeds candidate store");
    a_over_full: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(over_reg) |-> kept_reg == TCW'(MAX_SPACES))
        else $error("overflow raised with room left in the table");
`endif

endmodule
